/* hdl/gdd_pkg.sv */
// ----------------------------------------------------------------------------
// gdd_pkg
// Types, constants and calendar helpers for the Gregorian date difference
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package gdd_pkg;

   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 12;
   localparam int COUNT_W  = 19;
   localparam int DIFF_W   = 20;

   localparam int DEF_MIN_YEAR = 1583;
   localparam int DEF_MAX_YEAR = 2399;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [DAY_W-1:0]   first_day;
      logic [MONTH_W-1:0] first_month;
      logic [YEAR_W-1:0]  first_year;
      logic [DAY_W-1:0]   second_day;
      logic [MONTH_W-1:0] second_month;
      logic [YEAR_W-1:0]  second_year;
   } req_data_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] day_difference;
      logic                     date_invalid;
   } rsp_data_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } gdd_cmd_type;

   typedef struct packed {
      logic walk_done;
      logic out_free;
   } gdd_sts_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } gdd_state_type;

   // y / 100 by reciprocal: exact for any 12-bit year.
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [22:0]       prod;
      logic [5:0]        q;
      logic [YEAR_W-1:0] r;
      prod = 23'(y) * 23'd1311;
      q    = prod[22:17];
      r    = y - (YEAR_W'(q) * YEAR_W'(7'd100));
      return (r != '0) ? (y[1:0] == 2'd0) : (q[1:0] == 2'd0);
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
         MONTH_FEB:                                    len = leap ? 5'd29 : 5'd28;
         default:                                      len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic date_ok(input logic [DAY_W-1:0]   d,
                                    input logic [MONTH_W-1:0] m,
                                    input logic [YEAR_W-1:0]  y,
                                    input logic [YEAR_W-1:0]  ymin,
                                    input logic [YEAR_W-1:0]  ymax);
      logic [DAY_W-1:0] len;
      len = month_len(m, is_leap(y));
      return (len != '0) && (y >= ymin) && (y <= ymax) && (d != '0) && (d <= len);
   endfunction

endpackage

`default_nettype wire

/* hdl/gregorian_date_difference.sv */
// On accept the dates are loaded, the earlier one is walked one day per cycle up to
// the later one, and the result is registered once the output is free; an invalid
// date pair skips the walk. No new item is taken while a walk is in progress.
// A new item is accepted while the previous result waits in the output register.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
// gregorian_date_difference
// Signed day count from the first Gregorian date to the second.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_difference #(
   parameter int MIN_YEAR = gdd_pkg::DEF_MIN_YEAR,
   parameter int MAX_YEAR = gdd_pkg::DEF_MAX_YEAR
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire gdd_pkg::req_data_type req_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      gdd_pkg::rsp_data_type rsp_data
);
   import gdd_pkg::*;

   gdd_cmd_type cmd;
   gdd_sts_type sts;

   gdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gdd_dp #(
      .MIN_YEAR (MIN_YEAR),
      .MAX_YEAR (MAX_YEAR)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block idle right after taking an item");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.date_invalid) |-> (rsp_data.day_difference == '0))
      else $error("invalid date pair with nonzero difference");

   a_result_from_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an item in progress");
`endif

endmodule

`default_nettype wire

/* hdl/gdd_ctrl.sv */
// ----------------------------------------------------------------------------
// gdd_ctrl
// Sequencer: takes an item, lets the datapath walk, releases the result.
// ----------------------------------------------------------------------------
`default_nettype none

module gdd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire gdd_pkg::gdd_sts_type sts,
   output      gdd_pkg::gdd_cmd_type cmd
);
   import gdd_pkg::*;

   gdd_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (sts.walk_done && sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_WALK: begin
            cmd.step   = !sts.walk_done;
            cmd.finish = sts.walk_done && sts.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hdl/gdd_dp.sv */
// ----------------------------------------------------------------------------
// gdd_dp
// Datapath: orders the dates, steps the earlier one a day per cycle and
// holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gdd_dp #(
   parameter int MIN_YEAR = gdd_pkg::DEF_MIN_YEAR,
   parameter int MAX_YEAR = gdd_pkg::DEF_MAX_YEAR
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gdd_pkg::req_data_type req_data,
   input  wire gdd_pkg::gdd_cmd_type  cmd,
   output      gdd_pkg::gdd_sts_type  sts,
   input  wire logic                  rsp_stall,
   output      logic                  rsp_valid,
   output      gdd_pkg::rsp_data_type rsp_data
);
   import gdd_pkg::*;

   localparam logic [YEAR_W-1:0] YMIN = YEAR_W'(MIN_YEAR);
   localparam logic [YEAR_W-1:0] YMAX = YEAR_W'(MAX_YEAR);

   logic [DAY_W-1:0]   walk_day_ff, walk_day_in;
   logic [MONTH_W-1:0] walk_month_ff, walk_month_in;
   logic [YEAR_W-1:0]  walk_year_ff, walk_year_in;
   logic [DAY_W-1:0]   tgt_day_ff, tgt_day_in;
   logic [MONTH_W-1:0] tgt_month_ff, tgt_month_in;
   logic [YEAR_W-1:0]  tgt_year_ff, tgt_year_in;
   logic [COUNT_W-1:0] day_count_ff, day_count_in;
   logic               order_swapped_ff, order_swapped_in;
   logic               invalid_ff, invalid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_data_type       rsp_data_ff, rsp_data_in;

   logic               swap;
   logic [DAY_W-1:0]   cur_len;
   logic [DIFF_W-1:0]  mag;

   // Later date by lexicographic year/month/day compare
   assign swap = {req_data.first_year, req_data.first_month, req_data.first_day} >
                 {req_data.second_year, req_data.second_month, req_data.second_day};

   assign cur_len = month_len(walk_month_ff, is_leap(walk_year_ff));
   assign mag     = {1'b0, day_count_ff};

   always_comb begin
      walk_day_in      = walk_day_ff;
      walk_month_in    = walk_month_ff;
      walk_year_in     = walk_year_ff;
      tgt_day_in       = tgt_day_ff;
      tgt_month_in     = tgt_month_ff;
      tgt_year_in      = tgt_year_ff;
      day_count_in     = day_count_ff;
      order_swapped_in = order_swapped_ff;
      invalid_in       = invalid_ff;

      if (cmd.load) begin
         invalid_in = !date_ok(req_data.first_day, req_data.first_month,
                               req_data.first_year, YMIN, YMAX) ||
                      !date_ok(req_data.second_day, req_data.second_month,
                               req_data.second_year, YMIN, YMAX);
         order_swapped_in = swap;
         day_count_in     = '0;
         if (swap) begin
            walk_day_in   = req_data.second_day;
            walk_month_in = req_data.second_month;
            walk_year_in  = req_data.second_year;
            tgt_day_in    = req_data.first_day;
            tgt_month_in  = req_data.first_month;
            tgt_year_in   = req_data.first_year;
         end else begin
            walk_day_in   = req_data.first_day;
            walk_month_in = req_data.first_month;
            walk_year_in  = req_data.first_year;
            tgt_day_in    = req_data.second_day;
            tgt_month_in  = req_data.second_month;
            tgt_year_in   = req_data.second_year;
         end
      end else if (cmd.step) begin
         if (day_count_ff != COUNT_MAX) day_count_in = day_count_ff + 1'b1;
         if (walk_day_ff >= cur_len) begin
            walk_day_in = 5'd1;
            if (walk_month_ff == MONTH_DEC) begin
               walk_month_in = 4'd1;
               walk_year_in  = walk_year_ff + 1'b1;
            end else begin
               walk_month_in = walk_month_ff + 1'b1;
            end
         end else begin
            walk_day_in = walk_day_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (cmd.finish) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.date_invalid = invalid_ff;
         if (invalid_ff) begin
            rsp_data_in.day_difference = '0;
         end else if (order_swapped_ff) begin
            rsp_data_in.day_difference = DIFF_W'(-mag);
         end else begin
            rsp_data_in.day_difference = mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_day_ff      <= '0;
         walk_month_ff    <= '0;
         walk_year_ff     <= '0;
         day_count_ff     <= '0;
         order_swapped_ff <= 1'b0;
         invalid_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         walk_day_ff      <= walk_day_in;
         walk_month_ff    <= walk_month_in;
         walk_year_ff     <= walk_year_in;
         day_count_ff     <= day_count_in;
         order_swapped_ff <= order_swapped_in;
         invalid_ff       <= invalid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_day_ff   <= tgt_day_in;
      tgt_month_ff <= tgt_month_in;
      tgt_year_ff  <= tgt_year_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign sts = '{walk_done: invalid_ff ||
                             ((walk_day_ff == tgt_day_ff) &&
                              (walk_month_ff == tgt_month_ff) &&
                              (walk_year_ff == tgt_year_ff)),
                  out_free:  !rsp_valid_ff || !rsp_stall};

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* tb/gregorian_date_difference_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_difference_test
// Self-checking bench for the date difference block. Date pairs are queued up
// front: a directed set covering range ends, leap and century rules, month and
// year rollover, equal dates and invalid dates, then random pairs that are
// mostly valid dates a few years apart, plus corrupted and raw pairs. Each
// accepted pair is predicted from day numbers and checked against the results
// in order, with random idling on both sides, one long receiver hold-off and
// one sender pause until the block has drained.
// ----------------------------------------------------------------------------
module gregorian_date_difference_test;
   import gdd_pkg::*;

   localparam int WATCHDOG_LIMIT = 1_000_000;  // longest walk spans ~298k days
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_ITEMS   = 78;
   localparam int HOLD_AT        = 30;         // results seen when the long hold starts
   localparam int HOLD_CYCLES    = 3000;
   localparam int PAUSE_AT       = 70;         // items sent when the sender waits for drain
   localparam int STEADY_FROM    = 45;
   localparam int STEADY_TO      = 65;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_data_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_data_type rsp_data;

   req_data_type pending_pairs[$];
   rsp_data_type expected_differences[$];

   logic req_taken   = 1'b0;
   int   sent_count  = 0;
   int   rsp_count   = 0;
   int   idle_cycles = 0;
   int   error_count = 0;
   int   hold_left   = 0;
   logic hold_done   = 1'b0;
   logic steady;

   assign steady = (rsp_count >= STEADY_FROM) && (rsp_count < STEADY_TO);

   gregorian_date_difference #(
      .MIN_YEAR(DEF_MIN_YEAR),
      .MAX_YEAR(DEF_MAX_YEAR)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- calendar
   function automatic int days_in_month(input int m, input int y);
      logic leap;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      case (m)
         2:                       return leap ? 29 : 28;
         4, 6, 9, 11:             return 30;
         1, 3, 5, 7, 8, 10, 12:   return 31;
         default:                 return 0;
      endcase
   endfunction

   function automatic logic date_valid(input int d, input int m, input int y);
      return (y >= DEF_MIN_YEAR) && (y <= DEF_MAX_YEAR) && (d >= 1)
             && (d <= days_in_month(m, y));
   endfunction

   function automatic int serial_day(input int d, input int m, input int y);
      int p;
      int n;
      p = y - 1;
      n = 365 * p + p / 4 - p / 100 + p / 400;
      for (int i = 1; i < m; i++) n += days_in_month(i, y);
      return n + d;
   endfunction

   function automatic rsp_data_type predict_difference(input req_data_type r);
      rsp_data_type res;
      int           span;
      res = '0;
      if (!date_valid(int'(r.first_day), int'(r.first_month), int'(r.first_year)) ||
          !date_valid(int'(r.second_day), int'(r.second_month), int'(r.second_year))) begin
         res.date_invalid = 1'b1;
         return res;
      end
      span = serial_day(int'(r.second_day), int'(r.second_month), int'(r.second_year))
           - serial_day(int'(r.first_day), int'(r.first_month), int'(r.first_year));
      // magnitude saturates at the counter width before the sign goes back on
      if (span > int'(COUNT_MAX)) span = int'(COUNT_MAX);
      if (span < -int'(COUNT_MAX)) span = -int'(COUNT_MAX);
      res.day_difference = DIFF_W'(span);
      return res;
   endfunction

   function automatic req_data_type date_pair(input int d1, input int m1, input int y1,
                                              input int d2, input int m2, input int y2);
      req_data_type r;
      r.first_day    = DAY_W'(d1);
      r.first_month  = MONTH_W'(m1);
      r.first_year   = YEAR_W'(y1);
      r.second_day   = DAY_W'(d2);
      r.second_month = MONTH_W'(m2);
      r.second_year  = YEAR_W'(y2);
      return r;
   endfunction

   task automatic pick_day_month(input int yr, output int m, output int d);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, days_in_month(m, yr));
   endtask

   // break exactly one field of an otherwise valid date
   task automatic corrupt_date(inout int d, inout int m, inout int y);
      int lim;
      case ($urandom_range(0, 3))
         0: begin
            lim = days_in_month(m, y);
            d = (lim == 31 || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(lim + 1, 31);
         end
         1: m = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15);
         2: y = $urandom_range(0, DEF_MIN_YEAR - 1);
         default: y = $urandom_range(DEF_MAX_YEAR + 1, 4095);
      endcase
   endtask

   function automatic logic take_break();
      return !steady && ($urandom_range(0, 99) < 16);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // ------------------------------------------------------------------ driver
   always @(negedge clock) begin : driver_proc
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         offer = (pending_pairs.size() != 0)
                 && !(sent_count == PAUSE_AT && expected_differences.size() != 0)
                 && !take_break();
         if (offer) begin
            req_data   <= pending_pairs.pop_front();
            req_valid  <= 1'b1;
            sent_count <= sent_count + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && rsp_count == HOLD_AT) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= take_break();
      end
   end

   // ----------------------------------------------------------------- monitor
   always @(posedge clock) begin : monitor_proc
      rsp_data_type want;
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            expected_differences.push_back(predict_difference(req_data));
         if (rsp_valid && !rsp_stall) begin
            rsp_count <= rsp_count + 1;
            if (expected_differences.size() == 0) begin
               report_mismatch("result with no item outstanding");
            end else begin
               want = expected_differences.pop_front();
               if (rsp_data.day_difference !== want.day_difference)
                  report_mismatch($sformatf("day_difference got %0d expected %0d",
                                            rsp_data.day_difference, want.day_difference));
               if (rsp_data.date_invalid !== want.date_invalid)
                  report_mismatch($sformatf("date_invalid got %b expected %b",
                                            rsp_data.date_invalid, want.date_invalid));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus
   initial begin : stimulus
      int d1, m1, y1, d2, m2, y2;
      int kind;

      pending_pairs.push_back(date_pair(29, 2, 2000, 29, 2, 2000));   // equal dates
      pending_pairs.push_back(date_pair(1, 1, 1583, 31, 12, 2399));   // full span forward
      pending_pairs.push_back(date_pair(31, 12, 2399, 1, 1, 1583));   // full span backward
      pending_pairs.push_back(date_pair(31, 12, 1999, 1, 1, 2000));   // year rollover
      pending_pairs.push_back(date_pair(28, 2, 2000, 1, 3, 2000));    // leap, /400
      pending_pairs.push_back(date_pair(28, 2, 1900, 1, 3, 1900));    // century, not leap
      pending_pairs.push_back(date_pair(1, 3, 2100, 28, 2, 2100));
      pending_pairs.push_back(date_pair(1, 3, 1600, 29, 2, 1600));
      pending_pairs.push_back(date_pair(31, 1, 2024, 1, 2, 2024));    // month rollover
      pending_pairs.push_back(date_pair(30, 11, 2398, 15, 3, 2399));
      pending_pairs.push_back(date_pair(5, 0, 2000, 5, 5, 2000));     // month zero
      pending_pairs.push_back(date_pair(5, 5, 2000, 5, 13, 2000));    // month past December
      pending_pairs.push_back(date_pair(0, 7, 2010, 3, 7, 2010));     // day zero
      pending_pairs.push_back(date_pair(1, 4, 2010, 31, 4, 2010));    // day past month end
      pending_pairs.push_back(date_pair(29, 2, 1900, 1, 1, 1950));    // Feb 29, century year
      pending_pairs.push_back(date_pair(1, 1, 2001, 29, 2, 2001));    // Feb 29, common year
      pending_pairs.push_back(date_pair(30, 2, 2000, 1, 1, 2000));
      pending_pairs.push_back(date_pair(31, 12, 1582, 1, 1, 1583));   // year below range
      pending_pairs.push_back(date_pair(31, 12, 2399, 1, 1, 2400));   // year above range
      pending_pairs.push_back(date_pair(31, 15, 4095, 1, 1, 2000));   // all ones
      pending_pairs.push_back(date_pair(0, 0, 0, 0, 0, 0));           // all zeros
      pending_pairs.push_back(date_pair(15, 6, 2000, 31, 15, 4095));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         kind = $urandom_range(0, 99);
         y1 = $urandom_range(DEF_MIN_YEAR, DEF_MAX_YEAR);
         if (kind < 34)
            y2 = y1 + $urandom_range(0, 30) - 15;
         else
            y2 = y1 + $urandom_range(0, 2) - 1;
         if (y2 < DEF_MIN_YEAR) y2 = DEF_MIN_YEAR;
         if (y2 > DEF_MAX_YEAR) y2 = DEF_MAX_YEAR;
         pick_day_month(y1, m1, d1);
         pick_day_month(y2, m2, d2);
         if (kind < 10) begin
            d1 = $urandom_range(0, 31);
            m1 = $urandom_range(0, 15);
            y1 = $urandom_range(0, 4095);
            d2 = $urandom_range(0, 31);
            m2 = $urandom_range(0, 15);
            y2 = $urandom_range(0, 4095);
         end else if (kind < 20) begin
            if ($urandom_range(0, 1) == 0)
               corrupt_date(d1, m1, y1);
            else
               corrupt_date(d2, m2, y2);
         end else if (kind < 26) begin
            d2 = d1;
            m2 = m1;
            y2 = y1;
         end
         pending_pairs.push_back(date_pair(d1, m1, y1, d2, m2, y2));
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(pending_pairs.size() == 0 && !req_valid && expected_differences.size() == 0)
             && idle_cycles < WATCHDOG_LIMIT)
         @(negedge clock);

      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
         $display("Simulation FAILED");
      end else begin
         repeat (DRAIN_CYCLES) @(negedge clock);
         if (error_count == 0)
            $display("Simulation PASSED");
         else
            $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/gdd_pkg.sv
hdl/gdd_ctrl.sv
hdl/gdd_dp.sv
hdl/gregorian_date_difference.sv
tb/gregorian_date_difference_test.sv
